[rtl/core/last_substring_match_finder_top_macros.svh]
// Assertion macros used by the last-occurrence substring search RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef LAST_SUBSTRING_MATCH_FINDER_TOP_MACROS_SVH
`define LAST_SUBSTRING_MATCH_FINDER_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define LSMF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LSMF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lsmf_pkg.sv]
// Package for the last-occurrence substring search block.
// Sizes, request and status codes, lane vector type. No dependencies.
package lsmf_pkg;

    localparam int NEEDLE_MAX = 32;
    localparam int COUNT_BITS = 32;
    localparam int LEN_BITS   = $clog2(NEEDLE_MAX + 1);
    localparam int OFFSET_W   = 32;

    // one byte per lane, lane 0 newest
    typedef logic [NEEDLE_MAX-1:0][7:0] lane_vec_t;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_NEEDLE = 2'd1,
        REQ_HAY    = 2'd2,
        REQ_FINISH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_FOUND      = 2'd0,
        ST_NOT_FOUND  = 2'd1,
        ST_NEEDLE_OVF = 2'd2,
        ST_HAY_OVF    = 2'd3
    } status_t;

endpackage

[rtl/core/last_substring_match_finder_top.sv]
// Top level of the last-occurrence substring search block.
// Depends on lsmf_pkg, lsmf_window_cmp and the assertion macro header.
//
//  channel | dir | tdata                  | tuser          | tlast
//  s_*     | in  | [7:0] data_byte        | [1:0] req_type | -
//  m_*     | out | [31:0] match_offset    | [1:0] status   | -
//
// One item per cycle while no finish item is held: an item is registered,
// then updates the search state and, for a finish, loads the result register.
// m_tvalid is driven from the result register, loaded as a finish item leaves the input register.
// Reset clears all control and search state; needle bytes stay unset.
// A finish item waits in the input register only while an earlier result
// is still unread; other items pass regardless of the output side.
`include "last_substring_match_finder_top_macros.svh"

module last_substring_match_finder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] match_offset
    output logic [1:0]  m_tuser    // [1:0] status
);
    import lsmf_pkg::*;

    // input register
    logic                  in_valid_reg;
    req_t                  in_req_reg;
    logic [7:0]            in_byte_reg;
    logic                  advance;

    // search state
    lane_vec_t             needle_reg, needle_next;
    lane_vec_t             window_reg, window_next;
    lane_vec_t             window_shift;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next, cnt_inc;
    logic [COUNT_BITS-1:0] last_off_reg, last_off_next;
    logic                  seen_reg, seen_next;
    logic                  nov_reg, nov_next;
    logic                  hov_reg, hov_next;
    logic                  match;

    // result register
    logic                  out_valid_reg;
    status_t               out_status_reg, out_status_next;
    logic [OFFSET_W-1:0]   out_off_reg, out_off_next;
    logic                  load_result;

    // a finish item holds only while the previous result is unread
    assign advance     = !(in_req_reg == REQ_FINISH && out_valid_reg && !m_tready);
    assign s_tready    = !in_valid_reg || advance;
    assign load_result = in_valid_reg && (in_req_reg == REQ_FINISH) && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_req_reg  <= req_t'(s_tuser);
            in_byte_reg <= s_tdata;
        end
    end

    // window with the new byte shifted in at lane 0
    always_comb
    begin
        window_shift[0] = in_byte_reg;
        for (int j = 1; j < NEEDLE_MAX; j++)
        begin
            window_shift[j] = window_reg[j-1];
        end
    end

    lsmf_window_cmp u_cmp (
        .needle (needle_reg),
        .window (window_shift),
        .len    (len_reg),
        .match  (match)
    );

    assign cnt_inc = cnt_reg + COUNT_BITS'(1);

    // state update for the registered item
    always_comb
    begin
        needle_next   = needle_reg;
        window_next   = window_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        last_off_next = last_off_reg;
        seen_next     = seen_reg;
        nov_next      = nov_reg;
        hov_next      = hov_reg;
        if (in_valid_reg)
        begin
            case (in_req_reg)
                REQ_START:
                begin
                    window_next   = '0;
                    len_next      = '0;
                    cnt_next      = '0;
                    last_off_next = '0;
                    seen_next     = 1'b0;
                    nov_next      = 1'b0;
                    hov_next      = 1'b0;
                end
                REQ_NEEDLE:
                begin
                    // needle bytes count only before any haystack byte
                    if (cnt_reg == '0 && !hov_reg)
                    begin
                        if (len_reg < LEN_BITS'(NEEDLE_MAX))
                        begin
                            // aligned needle: newest byte at lane 0
                            needle_next[0] = in_byte_reg;
                            for (int j = 1; j < NEEDLE_MAX; j++)
                            begin
                                needle_next[j] = needle_reg[j-1];
                            end
                            len_next = len_reg + LEN_BITS'(1);
                        end
                        else
                        begin
                            nov_next = 1'b1;
                        end
                    end
                end
                REQ_HAY:
                begin
                    if (&cnt_reg)
                    begin
                        hov_next = 1'b1;
                    end
                    else
                    begin
                        window_next = window_shift;
                        cnt_next    = cnt_inc;
                        if (len_reg != '0 && cnt_inc >= COUNT_BITS'(len_reg) && match)
                        begin
                            last_off_next = cnt_inc - COUNT_BITS'(len_reg);
                            seen_next     = 1'b1;
                        end
                    end
                end
                default:
                begin
                    // finish leaves the state alone
                end
            endcase
        end
    end

    // finish result, overflow first
    always_comb
    begin
        if (nov_reg)
        begin
            out_status_next = ST_NEEDLE_OVF;
            out_off_next    = '0;
        end
        else if (hov_reg)
        begin
            out_status_next = ST_HAY_OVF;
            out_off_next    = '0;
        end
        else if (len_reg == '0)
        begin
            out_status_next = ST_FOUND;
            out_off_next    = OFFSET_W'(cnt_reg);
        end
        else if (seen_reg)
        begin
            out_status_next = ST_FOUND;
            out_off_next    = OFFSET_W'(last_off_reg);
        end
        else
        begin
            out_status_next = ST_NOT_FOUND;
            out_off_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            len_reg      <= '0;
            cnt_reg      <= '0;
            last_off_reg <= '0;
            seen_reg     <= 1'b0;
            nov_reg      <= 1'b0;
            hov_reg      <= 1'b0;
        end
        else
        begin
            window_reg   <= window_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            last_off_reg <= last_off_next;
            seen_reg     <= seen_next;
            nov_reg      <= nov_next;
            hov_reg      <= hov_next;
        end
    end

    // needle bytes carry no reset
    always_ff @(posedge clk)
    begin
        needle_reg <= needle_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            out_status_reg <= out_status_next;
            out_off_reg    <= out_off_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_off_reg;
    assign m_tuser  = out_status_reg;

    // checks
    `LSMF_ASSERT_SAME(a_len_cap, 1'b1, len_reg <= LEN_BITS'(NEEDLE_MAX), "needle length over capacity")
    `LSMF_ASSERT_NEXT(a_len_frozen, cnt_reg != '0, len_reg == $past(len_reg) || len_reg == '0, "needle grew after haystack")
    `LSMF_ASSERT_SAME(a_zero_off, m_tvalid && m_tuser != ST_FOUND, m_tdata == '0, "offset set on a failed search")

endmodule

[rtl/core/lsmf_window_cmp.sv]
// Parallel lane compare of the aligned needle against the haystack window.
// Depends on lsmf_pkg.
module lsmf_window_cmp (
    input  lsmf_pkg::lane_vec_t              needle,  // lane j: needle byte len-1-j
    input  lsmf_pkg::lane_vec_t              window,  // lane j: j-th newest haystack byte
    input  logic [lsmf_pkg::LEN_BITS-1:0]    len,
    output logic                             match
);
    import lsmf_pkg::*;

    logic [NEEDLE_MAX-1:0] lane_ok;

    // lanes at or above the needle length always agree
    always_comb
    begin
        for (int j = 0; j < NEEDLE_MAX; j++)
        begin
            lane_ok[j] = (LEN_BITS'(j) >= len) || (needle[j] == window[j]);
        end
    end

    assign match = &lane_ok;

endmodule
